// ===== hdl/mexp_pkg.sv =====
package mexp_pkg;

    // modulus after reset, before any write on the configuration channel
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage

// ===== hdl/mexp_if.sv =====
interface mexp_req_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] base;
    logic [W-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] residue;

    modport source (output valid, output residue, input ready);
    modport sink (input valid, input residue, output ready);
endinterface

interface mexp_cfg_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink (input valid, input modulus, output ready);
endinterface

// ===== hdl/mexp_modmul.sv =====
// (a * b) mod m: one registered multiply, then a restoring reduction
// that shifts in one product bit per cycle. Needs a, b < 2^W and m != 0.
module mexp_modmul #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CW = $clog2(2 * W);

    logic [2*W-1:0] prod_reg, prod_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [W:0]     trial;
    logic [W:0]     diff;

    assign trial = {rem_reg, prod_reg[2*W-1]};
    assign diff  = trial - {1'b0, m};

    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = {{W{1'b0}}, a} * {{W{1'b0}}, b};
            rem_next  = '0;
            cnt_next  = CW'(2 * W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {prod_reg[2*W-2:0], 1'b0};
            // remainder stays below m, so the difference fits in W bits
            if (trial >= {1'b0, m})
                rem_next = diff[W-1:0];
            else
                rem_next = trial[W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = rem_reg;

endmodule

// ===== hdl/modular_exponentiation.sv =====
// Modular exponentiation: residue = base ^ exponent mod modulus.
// req carries base and exponent; rsp returns the residue; cfg writes the
// modulus (always ready, write only while no request is in flight).
// Right-to-left square-and-multiply on one shared modular multiplier:
// a registered W x W multiply followed by a bit-serial reducer.
// A request costs one base reduction plus, per exponent bit up to the
// highest set bit, one square and one more product when the bit is set.
// A zero modulus answers 0 without starting the multiplier.
// req.ready is high only while idle. The result sits in an output register;
// a new request is taken while it waits, and the sequencer holds its next
// result until rsp drains the register, so a stalled receiver loses nothing.
// Reset (rst_n, async, active low) drops any request in flight, clears the
// result valid and loads the modulus with 1000000007.
module modular_exponentiation #(
    parameter int WORD_BITS = 32
) (
    input logic         clk,
    input logic         rst_n,
    mexp_req_if.sink    req,
    mexp_rsp_if.source  rsp,
    mexp_cfg_if.sink    cfg
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BASE   = 3'd1;
    localparam logic [2:0] S_BASE_W = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_MUL_W  = 3'd4;
    localparam logic [2:0] S_SQ_W   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    localparam logic [WORD_BITS-1:0] ONE_W     = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] MOD_RESET = WORD_BITS'(mexp_pkg::MODULUS_RESET);

    logic [2:0]           state_reg, state_next;
    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] sq_reg, sq_next;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] residue_reg, residue_next;

    logic                 mm_start;
    logic                 mm_busy;
    logic                 mm_done;
    logic [WORD_BITS-1:0] op_a;
    logic [WORD_BITS-1:0] op_b;
    logic [WORD_BITS-1:0] mm_result;

    mexp_modmul #(.W(WORD_BITS)) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (op_a),
        .b      (op_b),
        .m      (modulus_reg),
        .busy   (mm_busy),
        .done   (mm_done),
        .result (mm_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        residue_next   = residue_reg;
        mm_start       = 1'b0;
        op_a           = sq_reg;
        op_b           = sq_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    sq_next    = req.base;
                    exp_next   = req.exponent;
                    // 1 mod m: zero only for a modulus of one
                    acc_next   = (modulus_reg == ONE_W) ? '0 : ONE_W;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                if (modulus_reg == '0)
                begin
                    acc_next   = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    // base * 1 reduces the base
                    mm_start   = 1'b1;
                    op_b       = ONE_W;
                    state_next = S_BASE_W;
                end
            end
            S_BASE_W:
            begin
                if (mm_done)
                begin
                    sq_next    = mm_result;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (exp_reg == '0)
                    state_next = S_FIN;
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    op_a       = acc_reg;
                    state_next = S_MUL_W;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = S_SQ_W;
                end
            end
            S_MUL_W:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_result;
                    mm_start   = 1'b1;
                    state_next = S_SQ_W;
                end
            end
            S_SQ_W:
            begin
                if (mm_done)
                begin
                    sq_next    = mm_result;
                    exp_next   = exp_reg >> 1;
                    state_next = S_STEP;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    residue_next   = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MOD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                modulus_reg <= cfg.modulus;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        exp_reg     <= exp_next;
        residue_reg <= residue_next;
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.residue = residue_reg;

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_busy)
        else $error("modmul started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> $past(mm_busy))
        else $error("modmul done without a running reduction");

    a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && state_next == S_IDLE) |=> out_valid_reg)
        else $error("finished result not presented");

endmodule
